>>> rtl/seekable_byte_port_storage_core_defines.svh
// Assertion macros shared by the seekable byte port storage RTL.
// Each macro expects clk and rst_n in the enclosing module.
`ifndef SEEKABLE_BYTE_PORT_STORAGE_CORE_DEFINES_SVH
`define SEEKABLE_BYTE_PORT_STORAGE_CORE_DEFINES_SVH

// same-cycle implication
`define SBPS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbps assertion failed");

// next-cycle implication
`define SBPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbps assertion failed");

`endif

>>> rtl/sbps_pkg.sv
// Shared constants, request codes and stage types for the byte port storage core.
// No dependencies.
`default_nettype none

package sbps_pkg;

    localparam int INPUT_DEPTH = 32768;
    localparam int STORE_DEPTH = 524288;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 16;
    localparam int PTR_W  = 24;
    localparam int IN_AW  = $clog2(INPUT_DEPTH);
    localparam int ST_AW  = $clog2(STORE_DEPTH);

    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_APPEND = 2'd2;

    localparam logic [7:0] PORT_IN_DATA = 8'd0;
    localparam logic [7:0] PORT_IN_SEEK = 8'd1;
    localparam logic [7:0] PORT_ST_DATA = 8'd2;
    localparam logic [7:0] PORT_ST_CTRL = 8'd3;

    localparam logic [1:0] ST_PHASE_HIGH = 2'd0;
    localparam logic [1:0] ST_PHASE_MID  = 2'd1;
    localparam logic [1:0] ST_PHASE_LOW  = 2'd2;

    typedef enum logic [1:0] {
        SRC_IMM   = 2'd0,
        SRC_INBUF = 2'd1,
        SRC_STORE = 2'd2
    } src_t;

    typedef struct packed {
        logic              valid;
        src_t              src;
        logic [BYTE_W-1:0] imm;
    } stage_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [IN_AW-1:0]  addr;
        logic [BYTE_W-1:0] wdata;
    } in_cmd_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ST_AW-1:0]  addr;
        logic [BYTE_W-1:0] wdata;
    } st_cmd_t;

endpackage

`default_nettype wire

>>> rtl/sbps_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module sbps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[addr] <= wdata;
        end
        if (en && !we)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/sbps_ctrl.sv
// Request decode, device registers, memory commands and store clearing pass.
// Depends on sbps_pkg and the assertion macro header.
`default_nettype none
`include "seekable_byte_port_storage_core_defines.svh"

module sbps_ctrl
    import sbps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  port,
    input  wire logic [7:0]  data,
    input  wire logic        advance,
    output stage_t           s1,
    output in_cmd_t          in_cmd,
    output st_cmd_t          st_cmd
);

    logic [POS_W-1:0] in_count_reg, in_count_next;
    logic [POS_W-1:0] in_pos_reg, in_pos_next;
    logic             in_phase_reg, in_phase_next;
    logic [PTR_W-1:0] st_ptr_reg, st_ptr_next;
    logic [1:0]       st_phase_reg, st_phase_next;
    logic             clr_active_reg, clr_active_next;
    logic [ST_AW-1:0] clr_addr_reg, clr_addr_next;
    stage_t           s1_reg, s1_next;

    logic acc;
    logic in_pos_ok;
    logic in_full;
    logic st_ok;

    assign in_stall = clr_active_reg || (s1_reg.valid && !advance);
    assign acc      = in_valid && !in_stall;

    assign in_pos_ok = ({1'b0, in_pos_reg} < {1'b0, in_count_reg})
                    && ({1'b0, in_pos_reg} < (POS_W+1)'(INPUT_DEPTH));
    assign in_full   = !({1'b0, in_count_reg} < (POS_W+1)'(INPUT_DEPTH));
    assign st_ok     = {1'b0, st_ptr_reg} < (PTR_W+1)'(STORE_DEPTH);

    always_comb
    begin
        in_count_next   = in_count_reg;
        in_pos_next     = in_pos_reg;
        in_phase_next   = in_phase_reg;
        st_ptr_next     = st_ptr_reg;
        st_phase_next   = st_phase_reg;
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        in_cmd          = '0;
        st_cmd          = '0;
        s1_next         = s1_reg;

        if (clr_active_reg)
        begin
            st_cmd.en     = 1'b1;
            st_cmd.we     = 1'b1;
            st_cmd.addr   = clr_addr_reg;
            st_cmd.wdata  = '0;
            clr_addr_next = clr_addr_reg + ST_AW'(1);
            if (clr_addr_reg == ST_AW'(STORE_DEPTH - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
        else if (acc)
        begin
            s1_next.valid = 1'b1;
            s1_next.src   = SRC_IMM;
            s1_next.imm   = '0;
            case (kind)
                KIND_READ:
                begin
                    case (port)
                        PORT_IN_DATA:
                        begin
                            if (in_pos_ok)
                            begin
                                in_cmd.en   = 1'b1;
                                in_cmd.addr = in_pos_reg[IN_AW-1:0];
                                s1_next.src = SRC_INBUF;
                                in_pos_next = in_pos_reg + POS_W'(1);
                            end
                        end
                        PORT_IN_SEEK:
                        begin
                            s1_next.imm   = in_phase_reg ? in_pos_reg[7:0] : in_pos_reg[15:8];
                            in_phase_next = !in_phase_reg;
                        end
                        PORT_ST_DATA:
                        begin
                            if (st_ok)
                            begin
                                st_cmd.en   = 1'b1;
                                st_cmd.addr = st_ptr_reg[ST_AW-1:0];
                                s1_next.src = SRC_STORE;
                                st_ptr_next = st_ptr_reg + PTR_W'(1);
                            end
                        end
                        PORT_ST_CTRL:
                        begin
                            if (st_phase_reg != ST_PHASE_HIGH)
                            begin
                                s1_next.imm = {6'd0, st_phase_reg};
                            end
                            else
                            begin
                                s1_next.imm = {7'd0, !st_ok};
                            end
                        end
                        default:
                        begin
                            s1_next.imm = '0;
                        end
                    endcase
                end
                KIND_WRITE:
                begin
                    case (port)
                        PORT_IN_SEEK:
                        begin
                            if (in_phase_reg)
                            begin
                                in_pos_next = in_pos_reg | {8'd0, data};
                            end
                            else
                            begin
                                in_pos_next = {data, 8'd0};
                            end
                            in_phase_next = !in_phase_reg;
                        end
                        PORT_ST_DATA:
                        begin
                            if (st_ok)
                            begin
                                st_cmd.en    = 1'b1;
                                st_cmd.we    = 1'b1;
                                st_cmd.addr  = st_ptr_reg[ST_AW-1:0];
                                st_cmd.wdata = data;
                                st_ptr_next  = st_ptr_reg + PTR_W'(1);
                            end
                        end
                        PORT_ST_CTRL:
                        begin
                            case (st_phase_reg)
                                ST_PHASE_HIGH:
                                begin
                                    st_ptr_next   = {data, 16'd0};
                                    st_phase_next = ST_PHASE_MID;
                                end
                                ST_PHASE_MID:
                                begin
                                    st_ptr_next   = st_ptr_reg | {8'd0, data, 8'd0};
                                    st_phase_next = ST_PHASE_LOW;
                                end
                                default:
                                begin
                                    st_ptr_next   = st_ptr_reg | {16'd0, data};
                                    st_phase_next = ST_PHASE_HIGH;
                                end
                            endcase
                        end
                        default:
                        begin
                            st_phase_next = st_phase_reg;
                        end
                    endcase
                end
                KIND_APPEND:
                begin
                    if (!in_full)
                    begin
                        in_cmd.en     = 1'b1;
                        in_cmd.we     = 1'b1;
                        in_cmd.addr   = in_count_reg[IN_AW-1:0];
                        in_cmd.wdata  = data;
                        in_count_next = in_count_reg + POS_W'(1);
                    end
                end
                default:
                begin
                    s1_next.imm = '0;
                end
            endcase
        end
        else if (advance)
        begin
            s1_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg   <= '0;
            in_pos_reg     <= '0;
            in_phase_reg   <= 1'b0;
            st_ptr_reg     <= '0;
            st_phase_reg   <= ST_PHASE_HIGH;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_reg         <= '0;
        end
        else
        begin
            in_count_reg   <= in_count_next;
            in_pos_reg     <= in_pos_next;
            in_phase_reg   <= in_phase_next;
            st_ptr_reg     <= st_ptr_next;
            st_phase_reg   <= st_phase_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s1_reg         <= s1_next;
        end
    end

    assign s1 = s1_reg;

    `SBPS_ASSERT_IMPL(a_clr_stall, clr_active_reg, in_stall)
    `SBPS_ASSERT_NEXT(a_acc_stage, in_valid && !in_stall, s1_reg.valid)
    `SBPS_ASSERT_NEXT(a_full_hold, acc && kind == KIND_APPEND && in_full, $stable(in_count_reg))

endmodule

`default_nettype wire

>>> rtl/sbps_resp.sv
// Result select and output register with backpressure toward the decode stage.
// Depends on sbps_pkg and the assertion macro header.
`default_nettype none
`include "seekable_byte_port_storage_core_defines.svh"

module sbps_resp
    import sbps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire stage_t            s1,
    input  wire logic [BYTE_W-1:0] in_rdata,
    input  wire logic [BYTE_W-1:0] st_rdata,
    input  wire logic              out_stall,
    output logic                   advance,
    output logic                   out_valid,
    output logic      [BYTE_W-1:0] read_data
);

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] read_data_reg, read_data_next;
    logic [BYTE_W-1:0] sel_data;

    assign advance = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (s1.src)
            SRC_INBUF: sel_data = in_rdata;
            SRC_STORE: sel_data = st_rdata;
            default:   sel_data = s1.imm;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;
        if (advance)
        begin
            out_valid_next = s1.valid;
            read_data_next = sel_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    `SBPS_ASSERT_IMPL(a_hold_blocks, out_valid_reg && out_stall, !advance)
    `SBPS_ASSERT_NEXT(a_move_out, s1.valid && advance, out_valid_reg)
    `SBPS_ASSERT_NEXT(a_drain, !s1.valid && advance, !out_valid_reg)

endmodule

`default_nettype wire

>>> rtl/seekable_byte_port_storage_core.sv
// Seekable byte port storage core: input stream device and byte store on I/O ports.
// A result passes the memory read register and then the output register after acceptance.
// Throughput: one request per cycle while in_stall is low; a single port on each memory
// carries one access a request. Reset: registers clear at once; the store is then zeroed
// one byte a cycle with in_stall high. The input buffer is not cleared.
`default_nettype none

module seekable_byte_port_storage_core
    import sbps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  port,
    input  wire logic [7:0]  data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       read_data
);

    stage_t            s1;
    in_cmd_t           in_cmd;
    st_cmd_t           st_cmd;
    logic              advance;
    logic [BYTE_W-1:0] in_rdata;
    logic [BYTE_W-1:0] st_rdata;

    sbps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .port     (port),
        .data     (data),
        .advance  (advance),
        .s1       (s1),
        .in_cmd   (in_cmd),
        .st_cmd   (st_cmd)
    );

    sbps_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (INPUT_DEPTH)
    ) u_in_ram (
        .clk   (clk),
        .en    (in_cmd.en),
        .we    (in_cmd.we),
        .addr  (in_cmd.addr),
        .wdata (in_cmd.wdata),
        .rdata (in_rdata)
    );

    sbps_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_st_ram (
        .clk   (clk),
        .en    (st_cmd.en),
        .we    (st_cmd.we),
        .addr  (st_cmd.addr),
        .wdata (st_cmd.wdata),
        .rdata (st_rdata)
    );

    sbps_resp u_resp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1        (s1),
        .in_rdata  (in_rdata),
        .st_rdata  (st_rdata),
        .out_stall (out_stall),
        .advance   (advance),
        .out_valid (out_valid),
        .read_data (read_data)
    );

endmodule

`default_nettype wire

>>> sim/seekable_byte_port_storage_core_tb.sv
// Self-checking testbench for seekable_byte_port_storage_core: directed and random port traffic.
// Predicts every read byte with its own model of both devices; needs sbps_pkg and the core RTL.
module seekable_byte_port_storage_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbps_pkg::*;

    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int IDLE_PERCENT   = 26;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [1:0] KIND_NONE              = 2'd3;
    localparam logic [7:0] PORT_ERR_OUT           = 8'd4;
    localparam logic [7:0] PORT_UNMAPPED          = 8'hff;
    localparam logic [7:0] ST_STATUS_IN_RANGE     = 8'd0;
    localparam logic [7:0] ST_STATUS_OUT_OF_RANGE = 8'd1;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] port;
        logic [7:0] data;
        logic [7:0] read_data;
    } port_access_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] kind;
    logic [7:0] port;
    logic [7:0] data;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] read_data;

    logic [7:0]        stream_bytes [INPUT_DEPTH];
    logic [15:0]       stream_count;
    logic [15:0]       stream_pos;
    logic              stream_tell_phase;
    bit   [7:0]        store_image [STORE_DEPTH];
    logic [PTR_W-1:0]  store_ptr;
    logic [1:0]        store_phase;

    port_access_t expected_reads [$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           requests_sent = 0;
    bit           source_steady = 1'b0;
    bit           sink_steady = 1'b0;
    int           holdoff_asks = 0;
    int           holdoff_seen = 0;
    int           holdoff_left = 0;

    seekable_byte_port_storage_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .port      (port),
        .data      (data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .read_data (read_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("seekable_byte_port_storage_core_tb: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (holdoff_asks != holdoff_seen)
        begin
            holdoff_seen <= holdoff_asks;
            holdoff_left <= HOLDOFF_CYCLES;
            out_stall    <= 1'b1;
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
            out_stall    <= 1'b1;
        end
        else if (sink_steady)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        port_access_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reads.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: read_data %02h", read_data);
            end
            else
            begin
                want = expected_reads.pop_front();
                if (read_data !== want.read_data)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: kind %0d port %02h data %02h expected %02h got %02h",
                                 want.kind, want.port, want.data, want.read_data, read_data);
                end
            end
        end
    end

    function automatic logic [7:0] predict_read_data(logic [1:0] k, logic [7:0] p,
                                                     logic [7:0] d);
        logic [7:0] rv;
        rv = 8'h00;
        if (k == KIND_READ)
        begin
            case (p)
                PORT_IN_DATA:
                    if (stream_pos < stream_count && stream_pos < INPUT_DEPTH)
                    begin
                        rv = stream_bytes[stream_pos[IN_AW-1:0]];
                        stream_pos = stream_pos + 16'd1;
                    end
                PORT_IN_SEEK:
                    if (stream_tell_phase)
                    begin
                        rv = stream_pos[7:0];
                        stream_tell_phase = 1'b0;
                    end
                    else
                    begin
                        rv = stream_pos[15:8];
                        stream_tell_phase = 1'b1;
                    end
                PORT_ST_DATA:
                    if (store_ptr < STORE_DEPTH)
                    begin
                        rv = store_image[store_ptr[ST_AW-1:0]];
                        store_ptr = store_ptr + 24'd1;
                    end
                PORT_ST_CTRL:
                    if (store_phase != ST_PHASE_HIGH)
                        rv = {6'd0, store_phase};
                    else if (store_ptr >= STORE_DEPTH)
                        rv = ST_STATUS_OUT_OF_RANGE;
                    else
                        rv = ST_STATUS_IN_RANGE;
                default:
                    rv = 8'h00;
            endcase
        end
        else if (k == KIND_WRITE)
        begin
            case (p)
                PORT_IN_SEEK:
                    if (stream_tell_phase)
                    begin
                        stream_pos = stream_pos | {8'h00, d};
                        stream_tell_phase = 1'b0;
                    end
                    else
                    begin
                        stream_pos = {d, 8'h00};
                        stream_tell_phase = 1'b1;
                    end
                PORT_ST_DATA:
                    if (store_ptr < STORE_DEPTH)
                    begin
                        store_image[store_ptr[ST_AW-1:0]] = d;
                        store_ptr = store_ptr + 24'd1;
                    end
                PORT_ST_CTRL:
                    if (store_phase == ST_PHASE_HIGH)
                    begin
                        store_ptr = {d, 16'h0000};
                        store_phase = ST_PHASE_MID;
                    end
                    else if (store_phase == ST_PHASE_MID)
                    begin
                        store_ptr = store_ptr | {8'h00, d, 8'h00};
                        store_phase = ST_PHASE_LOW;
                    end
                    else
                    begin
                        store_ptr = store_ptr | {16'h0000, d};
                        store_phase = ST_PHASE_HIGH;
                    end
                default:
                    ;
            endcase
        end
        else if (k == KIND_APPEND)
        begin
            if (stream_count < INPUT_DEPTH)
            begin
                stream_bytes[stream_count[IN_AW-1:0]] = d;
                stream_count = stream_count + 16'd1;
            end
        end
        return rv;
    endfunction

    task automatic issue_request(input logic [1:0] k, input logic [7:0] p, input logic [7:0] d);
        port_access_t acc;
        while (!source_steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        port     <= p;
        data     <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        acc.kind      = k;
        acc.port      = p;
        acc.data      = d;
        acc.read_data = predict_read_data(k, p, d);
        expected_reads.push_back(acc);
        requests_sent++;
    endtask

    task automatic seek_stream(input logic [15:0] pos);
        if (stream_tell_phase)
            issue_request(KIND_READ, PORT_IN_SEEK, 8'h00);
        issue_request(KIND_WRITE, PORT_IN_SEEK, pos[15:8]);
        issue_request(KIND_WRITE, PORT_IN_SEEK, pos[7:0]);
    endtask

    task automatic seek_store(input logic [7:0] hi, input logic [7:0] mid, input logic [7:0] lo);
        while (store_phase != ST_PHASE_HIGH)
            issue_request(KIND_WRITE, PORT_ST_CTRL, 8'($urandom_range(255)));
        issue_request(KIND_WRITE, PORT_ST_CTRL, hi);
        if ($urandom_range(99) < 30)
            issue_request(KIND_READ, PORT_ST_CTRL, 8'h00);
        issue_request(KIND_WRITE, PORT_ST_CTRL, mid);
        if ($urandom_range(99) < 30)
            issue_request(KIND_READ, PORT_ST_CTRL, 8'h00);
        issue_request(KIND_WRITE, PORT_ST_CTRL, lo);
    endtask

    task automatic test_reset_state();
        issue_request(KIND_READ, PORT_IN_DATA, 8'h00);
        issue_request(KIND_READ, PORT_ST_DATA, 8'h00);
        issue_request(KIND_READ, PORT_ST_CTRL, 8'h00);
        issue_request(KIND_NONE, PORT_ST_CTRL, 8'hff);
        issue_request(KIND_READ, PORT_UNMAPPED, 8'hff);
    endtask

    task automatic test_input_stream();
        issue_request(KIND_APPEND, PORT_IN_DATA, 8'h00);
        issue_request(KIND_APPEND, PORT_UNMAPPED, 8'hff);
        repeat (3)
            issue_request(KIND_READ, PORT_IN_DATA, 8'h00);
        issue_request(KIND_WRITE, PORT_IN_SEEK, 8'h00);
        issue_request(KIND_WRITE, PORT_IN_SEEK, 8'h01);
        issue_request(KIND_READ, PORT_IN_DATA, 8'h00);
        issue_request(KIND_READ, PORT_IN_SEEK, 8'h00);
        issue_request(KIND_READ, PORT_IN_SEEK, 8'h00);
        issue_request(KIND_WRITE, PORT_IN_DATA, 8'h5a);
    endtask

    task automatic test_store_limits();
        issue_request(KIND_WRITE, PORT_ST_CTRL, 8'h07);
        issue_request(KIND_READ, PORT_ST_CTRL, 8'h00);
        issue_request(KIND_WRITE, PORT_ST_CTRL, 8'hff);
        issue_request(KIND_READ, PORT_ST_CTRL, 8'h00);
        issue_request(KIND_WRITE, PORT_ST_CTRL, 8'hff);
        issue_request(KIND_WRITE, PORT_ST_DATA, 8'ha5);
        issue_request(KIND_READ, PORT_ST_CTRL, 8'h00);
        issue_request(KIND_READ, PORT_ST_DATA, 8'h00);
        issue_request(KIND_WRITE, PORT_ERR_OUT, 8'hc3);
    endtask

    task automatic run_mixed_traffic(input int n_requests);
        int          stop_at;
        int          pick;
        int          span;
        logic [15:0] pos;
        logic [7:0]  hi;
        logic [7:0]  mid;
        stop_at = requests_sent + n_requests;
        while (requests_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                repeat ($urandom_range(1, 8))
                    issue_request(KIND_APPEND, 8'($urandom_range(255)),
                                  8'($urandom_range(255)));
            end
            else if (pick < 30)
            begin
                repeat ($urandom_range(1, 6))
                    issue_request(KIND_READ, PORT_IN_DATA, 8'($urandom_range(255)));
            end
            else if (pick < 40)
            begin
                if ($urandom_range(7) == 0)
                    pos = 16'($urandom_range(16'hffff));
                else
                    pos = 16'($urandom_range(0, int'(stream_count) + 3));
                seek_stream(pos);
            end
            else if (pick < 47)
            begin
                repeat (2)
                    issue_request(KIND_READ, PORT_IN_SEEK, 8'($urandom_range(255)));
            end
            else if (pick < 60)
            begin
                span = $urandom_range(99);
                if (span < 65)
                    hi = 8'h00;
                else if (span < 80)
                    hi = 8'($urandom_range(7));
                else if (span < 90)
                    hi = 8'h07;
                else
                    hi = 8'($urandom_range(255));
                if (hi == 8'h00)
                    mid = 8'($urandom_range(3));
                else if (span >= 80 && span < 90)
                    mid = 8'hff;
                else
                    mid = 8'($urandom_range(255));
                seek_store(hi, mid, (span >= 80 && span < 90) ?
                           8'($urandom_range(8'hf0, 8'hff)) : 8'($urandom_range(255)));
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 8))
                    issue_request($urandom_range(1) ? KIND_WRITE : KIND_READ, PORT_ST_DATA,
                                  8'($urandom_range(255)));
            end
            else if (pick < 85)
                issue_request(KIND_READ, PORT_ST_CTRL, 8'($urandom_range(255)));
            else
                issue_request(2'($urandom_range(3)),
                              $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255)),
                              8'($urandom_range(255)));
        end
    endtask

    task automatic test_mixed_traffic();
        run_mixed_traffic(1300);
    endtask

    task automatic test_full_rate();
        source_steady = 1'b1;
        sink_steady   = 1'b1;
        run_mixed_traffic(300);
        source_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    task automatic test_backpressure();
        holdoff_asks++;
        run_mixed_traffic(100);
    endtask

    task automatic test_input_tail();
        repeat (4)
            issue_request(KIND_APPEND, PORT_IN_DATA, 8'($urandom_range(255)));
        seek_stream(stream_count - 16'd2);
        repeat (4)
            issue_request(KIND_READ, PORT_IN_DATA, 8'h00);
        seek_stream(16'hffff);
        issue_request(KIND_READ, PORT_IN_DATA, 8'h00);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        kind              = KIND_READ;
        port              = PORT_IN_DATA;
        data              = 8'h00;
        stream_count      = 16'd0;
        stream_pos        = 16'd0;
        stream_tell_phase = 1'b0;
        store_ptr         = '0;
        store_phase       = ST_PHASE_HIGH;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_input_stream();
        test_store_limits();
        test_mixed_traffic();
        test_full_rate();
        test_backpressure();
        test_input_tail();

        in_valid <= 1'b0;
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("seekable_byte_port_storage_core_tb: clean");
        else
            $display("seekable_byte_port_storage_core_tb: errors");
        $finish;
    end

endmodule
